@@ rtl/scem_pkg.sv @@
// ----------------------------------------------------------------------------
// scem_pkg
// Shared types and constants for the seam cumulative energy map block.
// ----------------------------------------------------------------------------
package scem_pkg;

    localparam int ENERGY_W            = 8;
    localparam int CUM_W               = 19;
    localparam int CFG_W               = 11;
    localparam int STORE_W             = 20;
    localparam int SUM_W               = 21;
    localparam int MAX_LINE_LENGTH_DEF = 1024;
    localparam int MAX_LINES           = 2048;
    localparam int RESET_LINE_LENGTH   = 1024;

    // Saturation ceiling of a cumulative sum.
    localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(MAX_LINES * 255);

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                frame_start;
    } scem_in_t;

    typedef struct packed {
        logic [CUM_W-1:0] cumulative;
        logic             line_end;
    } scem_out_t;

endpackage

@@ rtl/scem_line_buf.sv @@
// ----------------------------------------------------------------------------
// scem_line_buf
// Previous-line store: two synchronous read ports, one write port, with
// forwarding of a write that lands on a read address in the same cycle.
// ----------------------------------------------------------------------------
module scem_line_buf #(
    parameter int DEPTH  = scem_pkg::MAX_LINE_LENGTH_DEF,
    parameter int ADDR_W = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr_c,
    input  logic [ADDR_W-1:0]            rd_addr_r,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [scem_pkg::STORE_W-1:0] wr_data,
    output logic [scem_pkg::STORE_W-1:0] center,
    output logic [scem_pkg::STORE_W-1:0] right
);
    import scem_pkg::*;

    logic [STORE_W-1:0] mem [DEPTH];
    logic [STORE_W-1:0] rd_c_reg;
    logic [STORE_W-1:0] rd_r_reg;
    logic [STORE_W-1:0] fwd_data_reg;
    logic               fwd_c_reg;
    logic               fwd_r_reg;

    // Read sees the old entry; a colliding write is caught by the forward path.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_c_reg     <= mem[rd_addr_c];
            rd_r_reg     <= mem[rd_addr_r];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_c_reg <= 1'b0;
            fwd_r_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_c_reg <= wr_en && (wr_addr == rd_addr_c);
            fwd_r_reg <= wr_en && (wr_addr == rd_addr_r);
        end
    end

    assign center = fwd_c_reg ? fwd_data_reg : rd_c_reg;
    assign right  = fwd_r_reg ? fwd_data_reg : rd_r_reg;

endmodule

@@ rtl/seam_cumulative_energy_map.sv @@
// ----------------------------------------------------------------------------
// seam_cumulative_energy_map
// Streaming cumulative seam energy: each pixel plus the least of its three
// upper neighbors from the previous line, saturating; first-line pixels pass their energy.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  pixel    | pixel_valid/stall   in | scem_in_t  {energy, frame_start}
//  result   | result_valid/stall out | scem_out_t {cumulative, line_end}
//  cfg      | cfg_valid/ready     in | cfg_data = line_length
//
//  One pixel per cycle sustained while results are not stalled; a taken
//  request passes the line buffer read into the add stage, then add/min
//  into the output register, from which the result leaves.
//  The line buffer gives one center and one right read per pixel and takes
//  the write-back of the previous pixel in the same cycle.
//  Reset clears position, first-line flag and valids; the buffer is not
//  cleared. A stalled result holds the add stage, which then stalls pixels.
// ----------------------------------------------------------------------------
module seam_cumulative_energy_map #(
    parameter int MAX_LINE_LENGTH = scem_pkg::MAX_LINE_LENGTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [scem_pkg::CFG_W-1:0] cfg_data,
    input  logic                       pixel_valid,
    output logic                       pixel_stall,
    input  scem_pkg::scem_in_t         pixel,
    output logic                       result_valid,
    input  logic                       result_stall,
    output scem_pkg::scem_out_t        result
);
    import scem_pkg::*;

    localparam int POS_W = (MAX_LINE_LENGTH > 1) ? $clog2(MAX_LINE_LENGTH) : 1;
    localparam int LEN_W = (POS_W + 1 > CFG_W) ? POS_W + 1 : CFG_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE_LENGTH);
    localparam logic [LEN_W-1:0] RST_LEN =
        (RESET_LINE_LENGTH > MAX_LINE_LENGTH) ? LEN_W'(MAX_LINE_LENGTH)
                                              : LEN_W'(RESET_LINE_LENGTH);
    localparam logic [POS_W-1:0] RST_LAST_IDX = POS_W'(RST_LEN - LEN_W'(1));

    // Configuration and line position
    logic [POS_W-1:0]    last_idx_reg, last_idx_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                first_reg, first_next;
    logic [LEN_W-1:0]    cfg_len;
    logic [LEN_W-1:0]    eff_len;

    // Add stage (line buffer data valid here)
    logic                a_valid_reg;
    logic [ENERGY_W-1:0] a_energy_reg;
    logic                a_first_reg;
    logic                a_last_reg;
    logic [POS_W-1:0]    a_pos_reg;
    logic [STORE_W-1:0]  held_left_reg;

    // Output register
    logic                out_valid_reg;
    scem_out_t           out_data_reg;

    logic                a_adv;
    logic                px_acc;
    logic [POS_W-1:0]    acc_pos;
    logic                acc_first;
    logic                acc_last;
    logic [POS_W-1:0]    rd_addr_r;
    logic [STORE_W-1:0]  center;
    logic [STORE_W-1:0]  right_raw;
    logic [STORE_W-1:0]  left_v;
    logic [STORE_W-1:0]  right_v;
    logic [STORE_W-1:0]  min_lc;
    logic [STORE_W-1:0]  min_all;
    logic [SUM_W-1:0]    sum_full;
    logic [SUM_W-1:0]    sum_sat;

    assign cfg_ready = 1'b1;

    // Clamp the programmed length to 1..MAX and keep its last index.
    always_comb
    begin
        cfg_len = LEN_W'(cfg_data);
        if (cfg_len == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (cfg_len > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = cfg_len;
        end
        last_idx_next = (cfg_valid && cfg_ready) ? POS_W'(eff_len - LEN_W'(1))
                                                 : last_idx_reg;
    end

    assign a_adv       = a_valid_reg && (!out_valid_reg || !result_stall);
    assign pixel_stall = a_valid_reg && !a_adv;
    assign px_acc      = pixel_valid && !pixel_stall;

    always_comb
    begin
        acc_pos    = pixel.frame_start ? '0 : pos_reg;
        acc_first  = pixel.frame_start || first_reg;
        acc_last   = (acc_pos >= last_idx_reg);
        rd_addr_r  = acc_last ? acc_pos : acc_pos + POS_W'(1);
        pos_next   = pos_reg;
        first_next = first_reg;
        if (px_acc)
        begin
            pos_next   = acc_last ? '0 : acc_pos + POS_W'(1);
            first_next = acc_last ? 1'b0 : acc_first;
        end
    end

    scem_line_buf #(
        .DEPTH  (MAX_LINE_LENGTH),
        .ADDR_W (POS_W)
    ) u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (px_acc),
        .rd_addr_c (acc_pos),
        .rd_addr_r (rd_addr_r),
        .wr_en     (a_adv),
        .wr_addr   (a_pos_reg),
        .wr_data   (sum_sat[STORE_W-1:0]),
        .center    (center),
        .right     (right_raw)
    );

    // Clamp neighbors at both line ends, take the minimum, add and saturate.
    always_comb
    begin
        left_v   = (a_pos_reg == '0) ? center : held_left_reg;
        right_v  = a_last_reg ? center : right_raw;
        min_lc   = (left_v < center) ? left_v : center;
        min_all  = (min_lc < right_v) ? min_lc : right_v;
        if (a_first_reg)
        begin
            sum_full = SUM_W'(a_energy_reg);
        end
        else
        begin
            sum_full = SUM_W'(a_energy_reg) + SUM_W'(min_all);
        end
        sum_sat = (sum_full > SAT_LIMIT) ? SAT_LIMIT : sum_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx_reg  <= RST_LAST_IDX;
            pos_reg       <= '0;
            first_reg     <= 1'b1;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            held_left_reg <= '0;
        end
        else
        begin
            last_idx_reg <= last_idx_next;
            pos_reg      <= pos_next;
            first_reg    <= first_next;
            if (px_acc)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv)
            begin
                out_valid_reg <= 1'b1;
                held_left_reg <= center;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (px_acc)
        begin
            a_energy_reg <= pixel.energy;
            a_first_reg  <= acc_first;
            a_last_reg   <= acc_last;
            a_pos_reg    <= acc_pos;
        end
        if (a_adv)
        begin
            out_data_reg.cumulative <= sum_sat[CUM_W-1:0];
            out_data_reg.line_end   <= a_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for seam_cumulative_energy_map. A queue of energy
// pixels feeds a clocked driver, a clocked monitor predicts each pixel's
// cumulative seam energy and compares it with the block's result, and a
// sequence of line-length settings walks through first lines, clamped
// neighbors, mid-line restarts and mid-line shrinks.
// ----------------------------------------------------------------------------
module tb_top;

    import scem_pkg::*;

    localparam int LINE_CAP  = MAX_LINE_LENGTH_DEF;
    localparam int HOLD_LONG = 80;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } flow_e;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data     = '0;
    logic                pixel_valid  = 1'b0;
    logic                pixel_stall;
    scem_in_t            pixel        = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    scem_out_t           result;

    scem_in_t            pixel_queue[$];
    scem_out_t           pending_cumulative[$];
    flow_e               flow         = FLOW_FREE;
    logic                hold_kick    = 1'b0;
    int unsigned         hold_left    = 0;
    int unsigned         mismatches   = 0;

    // Predictor state: previous line, position, first-line flag, saved
    // upper-left value and the line length register.
    logic [STORE_W-1:0]  line_mem [LINE_CAP];
    logic [9:0]          row_pos      = '0;
    logic                on_first_row = 1'b1;
    logic [STORE_W-1:0]  left_above   = '0;
    logic [CFG_W-1:0]    line_len_cfg = CFG_W'(RESET_LINE_LENGTH);

    seam_cumulative_energy_map dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic scem_out_t cumulative_for(input scem_in_t px);
        logic [CFG_W-1:0]   eff;
        logic [9:0]         p;
        logic               is_last;
        logic [STORE_W-1:0] c;
        logic [STORE_W-1:0] l;
        logic [STORE_W-1:0] r;
        logic [STORE_W-1:0] m;
        logic [SUM_W-1:0]   s;
        scem_out_t          o;
        eff = (line_len_cfg == '0) ? CFG_W'(1) :
              ((line_len_cfg > CFG_W'(LINE_CAP)) ? CFG_W'(LINE_CAP) : line_len_cfg);
        if (px.frame_start)
        begin
            row_pos      = '0;
            on_first_row = 1'b1;
        end
        p       = row_pos;
        is_last = ({1'b0, p} >= eff - CFG_W'(1));
        c       = line_mem[p];
        l       = (p == '0) ? c : left_above;
        // clamp the right neighbor at the line end
        r       = (is_last || p == 10'(LINE_CAP - 1)) ? c : line_mem[p + 10'd1];
        m       = (l < c) ? l : c;
        m       = (m < r) ? m : r;
        if (on_first_row)
            s = SUM_W'(px.energy);
        else
            s = SUM_W'(px.energy) + SUM_W'(m);
        if (s > SAT_LIMIT)
            s = SAT_LIMIT;
        left_above  = c;
        line_mem[p] = s[STORE_W-1:0];
        if (is_last)
        begin
            row_pos      = '0;
            on_first_row = 1'b0;
        end
        else
        begin
            row_pos = p + 10'd1;
        end
        o.cumulative = s[CUM_W-1:0];
        o.line_end   = is_last;
        return o;
    endfunction

    function automatic scem_in_t px(input int e, input bit fs);
        scem_in_t v;
        v.energy      = ENERGY_W'(e);
        v.frame_start = fs;
        return v;
    endfunction

    // Pixel driver: advance on acceptance, idle at random per the flow mode.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
        end
        else if (!pixel_valid || !pixel_stall)
        begin
            if (pixel_queue.size() != 0 &&
                !((flow == FLOW_SRC_GAPS && $urandom_range(99) < 53) ||
                  (flow == FLOW_BOTH && $urandom_range(99) < 21)))
            begin
                pixel_valid <= 1'b1;
                pixel       <= pixel_queue.pop_front();
            end
            else
            begin
                pixel_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick && hold_left == 0)
            hold_left <= HOLD_LONG;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= (hold_left != 0) ||
                            (flow == FLOW_SINK_STALLS && $urandom_range(99) < 53) ||
                            (flow == FLOW_BOTH && $urandom_range(99) < 21);
    end

    always @(posedge clk)
    begin
        scem_out_t exp_res;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                line_len_cfg = cfg_data;
            if (pixel_valid && !pixel_stall)
                pending_cumulative.push_back(cumulative_for(pixel));
            if (result_valid && !result_stall)
            begin
                if (pending_cumulative.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, actual %0d/%0b",
                             $time, result.cumulative, result.line_end);
                end
                else
                begin
                    exp_res = pending_cumulative.pop_front();
                    if (exp_res.cumulative !== result.cumulative)
                    begin
                        mismatches++;
                        $display("%0t cumulative mismatch: expected %0d, actual %0d",
                                 $time, exp_res.cumulative, result.cumulative);
                    end
                    if (exp_res.line_end !== result.line_end)
                    begin
                        mismatches++;
                        $display("%0t line_end mismatch: expected %0b, actual %0b",
                                 $time, exp_res.line_end, result.line_end);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || pixel_valid || pending_cumulative.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_line_length(input int v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Queue random pixels; hot pixels sit near full energy.
    task automatic run_phase(input int len_value, input int count, input bit fs_first,
                             input int fs_odds, input bit hot, input flow_e f,
                             input bit squeeze);
        scem_in_t v;
        wait_drained();
        write_line_length(len_value);
        @(negedge clk);
        flow = f;
        for (int i = 0; i < count; i++)
        begin
            if (hot)
                v.energy = ($urandom_range(15) == 0) ? ENERGY_W'($urandom)
                                                     : ENERGY_W'(255 - $urandom_range(3));
            else
                case ($urandom_range(7))
                    0:       v.energy = '0;
                    1:       v.energy = '1;
                    default: v.energy = ENERGY_W'($urandom);
                endcase
            v.frame_start = (i == 0 && fs_first) ||
                            (fs_odds != 0 && $urandom_range(fs_odds - 1) == 0);
            pixel_queue.push_back(v);
        end
        if (squeeze)
        begin
            hold_kick = 1'b1;
            @(negedge clk);
            hold_kick = 1'b0;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Three-pixel lines: clamps at both ends, a restart mid-line,
        // then shrink to length zero while mid-line.
        wait_drained();
        write_line_length(3);
        @(negedge clk);
        pixel_queue.push_back(px(255, 1));
        pixel_queue.push_back(px(0, 0));
        pixel_queue.push_back(px(128, 0));
        pixel_queue.push_back(px(0, 0));
        pixel_queue.push_back(px(255, 0));
        pixel_queue.push_back(px(1, 0));
        pixel_queue.push_back(px(7, 0));
        pixel_queue.push_back(px(0, 0));
        pixel_queue.push_back(px(255, 0));
        pixel_queue.push_back(px(3, 0));
        pixel_queue.push_back(px(9, 1));
        pixel_queue.push_back(px(2, 0));
        pixel_queue.push_back(px(4, 0));
        pixel_queue.push_back(px(6, 0));
        pixel_queue.push_back(px(1, 0));
        wait_drained();
        write_line_length(0);
        @(negedge clk);
        pixel_queue.push_back(px(200, 0));
        pixel_queue.push_back(px(255, 0));
        pixel_queue.push_back(px(0, 0));

        // Full-length lines, stopping part way into the second line.
        run_phase(1024, LINE_CAP + 55, 1'b1, 0, 1'b0, FLOW_BOTH, 1'b0);
        // Shrink mid-line, then random restarts.
        run_phase(50, 45, 1'b0, 60, 1'b0, FLOW_SRC_GAPS, 1'b0);
        run_phase(7, 45, 1'b1, 40, 1'b0, FLOW_FREE, 1'b1);
        run_phase(2, 45, 1'b1, 30, 1'b0, FLOW_SINK_STALLS, 1'b0);
        // One-pixel lines at high energy.
        run_phase(1, 45, 1'b1, 0, 1'b1, FLOW_BOTH, 1'b0);
        // Oversized setting clamps to the maximum length.
        run_phase(2047, 40, 1'b1, 0, 1'b0, FLOW_SINK_STALLS, 1'b0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (pending_cumulative.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
